@@ sv/ponv_pkg.sv @@
// Shared types and constants for the fractal Perlin noise volume block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package ponv_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int TABLE_SIZE    = 256;
  localparam int MAX_OCTAVES   = 8;
  localparam int OCT_W         = $clog2(MAX_OCTAVES);
  localparam int CFG_W         = 24;
  localparam int CFG_IDX_W     = 3;
  localparam int NOISE_W       = 19;
  localparam int TOTAL_W       = 40;
  localparam int AMP_SUM_W     = 20;
  localparam int COORD_DIVISOR = 5;
  localparam int CDIV_STEPS    = 5;
  localparam int RD_STEPS      = 14;
  localparam int LERP_STEPS    = 7;
  localparam int FADE_STEPS    = 3;

  // Permutation read sequence of one octave.
  localparam logic [3:0] RD_PX     = 4'd0;
  localparam logic [3:0] RD_PX1    = 4'd1;
  localparam logic [3:0] RD_PA     = 4'd2;
  localparam logic [3:0] RD_PA1    = 4'd3;
  localparam logic [3:0] RD_PB     = 4'd4;
  localparam logic [3:0] RD_PB1    = 4'd5;
  localparam logic [3:0] RD_CORNER = 4'd6;

  // Steps of the fade polynomial.
  localparam logic [1:0] FS_SQUARE = 2'd0;
  localparam logic [1:0] FS_CUBE   = 2'd1;
  localparam logic [1:0] FS_POLY   = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE    = 3'd0,
    CFG_OCTAVES  = 3'd1,
    CFG_PERSIST  = 3'd2,
    CFG_WIDTH    = 3'd3,
    CFG_HEIGHT   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic       func;
    logic [7:0] perm_index;
    logic [7:0] perm_value;
    logic [9:0] voxel_x;
    logic [9:0] voxel_y;
    logic [9:0] voxel_z;
  } item_t;

  typedef struct packed {
    logic [15:0] density;
    logic [29:0] voxel_index;
  } result_t;

  typedef struct packed {
    logic       perm_we;
    logic       eval_start;
    logic       mul_en;
    logic       cdiv_en;
    logic       fade_en;
    logic [1:0] fade_step;
    logic       rd_en;
    logic [3:0] rd_sel;
    logic       lerp_en;
    logic [2:0] lerp_step;
    logic       acc_en;
    logic       div_start;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [3:0] n_oct;
    logic       div_done;
  } status_t;

endpackage

`default_nettype wire

@@ sv/ponv_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on ponv_pkg for operand widths.
`default_nettype none

module ponv_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [ponv_pkg::TOTAL_W-1:0]       dividend_i,
  input  logic [ponv_pkg::AMP_SUM_W-1:0]     divisor_i,
  output logic [ponv_pkg::TOTAL_W-1:0]       quotient_o,
  output logic                               done_o
);

  localparam int CNT_W = $clog2(ponv_pkg::TOTAL_W);

  logic [ponv_pkg::TOTAL_W-1:0]   quo_q;
  logic [ponv_pkg::AMP_SUM_W-1:0] rem_q, rem_d;
  logic [ponv_pkg::AMP_SUM_W:0]   shifted, diff;
  logic                           ge;
  logic [CNT_W-1:0]               cnt_q;
  logic                           run_q, done_q;

  always_comb begin
    shifted = {rem_q, quo_q[ponv_pkg::TOTAL_W-1]};
    diff    = shifted - {1'b0, divisor_i};
    ge      = (shifted >= {1'b0, divisor_i});
    rem_d   = ge ? diff[ponv_pkg::AMP_SUM_W-1:0] : shifted[ponv_pkg::AMP_SUM_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (run_q) begin
      quo_q <= {quo_q[ponv_pkg::TOTAL_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ponv_pkg::TOTAL_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

@@ sv/ponv_dp.sv @@
// Datapath: configuration registers, coordinate scaling, permutation memory,
// fade lanes, shared lerp unit, octave accumulator and result register.
// Depends on ponv_pkg and instantiates ponv_div.
`default_nettype none

module ponv_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ponv_pkg::cmd_t                   cmd_i,
  output ponv_pkg::status_t                status_o,
  input  ponv_pkg::item_t                  item_i,
  input  logic                             cfg_we_i,
  input  logic [ponv_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ponv_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                             done_o,
  output ponv_pkg::result_t                result_o
);

  localparam int NW = ponv_pkg::NOISE_W;

  localparam logic [2:0] LS_Y0Z0 = 3'd0;
  localparam logic [2:0] LS_Y1Z0 = 3'd1;
  localparam logic [2:0] LS_Y0Z1 = 3'd2;
  localparam logic [2:0] LS_Y1Z1 = 3'd3;
  localparam logic [2:0] LS_Z0   = 3'd4;
  localparam logic [2:0] LS_Z1   = 3'd5;
  localparam logic [2:0] LS_OUT  = 3'd6;

  function automatic logic signed [NW-1:0] grad_f(input logic [3:0] h,
                                                  input logic signed [16:0] x,
                                                  input logic signed [16:0] y,
                                                  input logic signed [16:0] z);
    logic signed [NW-1:0] u, v;
    begin
      u = (h < 4'd8) ? NW'(x) : NW'(y);
      if (h < 4'd4) begin
        v = NW'(y);
      end else if (h == 4'd12 || h == 4'd14) begin
        v = NW'(x);
      end else begin
        v = NW'(z);
      end
      return (h[0] ? -u : u) + (h[1] ? -v : v);
    end
  endfunction

  // Configuration registers.
  logic [23:0] scale_q;
  logic [3:0]  oct_cfg_q;
  logic [15:0] pers_q;
  logic [10:0] vw_q, vh_q;
  logic [3:0]  n_oct;
  logic        div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= 24'd65536;
      oct_cfg_q <= 4'd4;
      pers_q    <= 16'd32768;
      vw_q      <= 11'd64;
      vh_q      <= 11'd64;
    end else if (cfg_we_i) begin
      case (ponv_pkg::cfg_idx_e'(cfg_idx_i))
        ponv_pkg::CFG_SCALE:   scale_q   <= cfg_data_i[23:0];
        ponv_pkg::CFG_OCTAVES: oct_cfg_q <= cfg_data_i[3:0];
        ponv_pkg::CFG_PERSIST: pers_q    <= cfg_data_i[15:0];
        ponv_pkg::CFG_WIDTH:   vw_q      <= cfg_data_i[10:0];
        ponv_pkg::CFG_HEIGHT:  vh_q      <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (oct_cfg_q == 4'd0) begin
      n_oct = 4'd1;
    end else if (oct_cfg_q > 4'(ponv_pkg::MAX_OCTAVES)) begin
      n_oct = 4'(ponv_pkg::MAX_OCTAVES);
    end else begin
      n_oct = oct_cfg_q;
    end
  end

  assign status_o = {n_oct, div_done};

  // Voxel, coordinate scaling and the linear index.
  logic [9:0]  vox_q   [3];
  logic [39:0] sh_q    [3];
  logic [2:0]  r_q     [3];
  logic [2:0]  r_nx    [3];
  logic [7:0]  qb      [3];
  logic [23:0] coord_q [3];
  logic [34:0] num     [3];
  logic [20:0] yw_q, zw_q;
  logic [31:0] zwh_full;
  logic [29:0] zwh_q, idx_q;

  // Long division by five, eight dividend bits per cycle.
  always_comb begin
    logic [2:0] rem_v;
    logic [3:0] rr;
    for (int a = 0; a < 3; a++) begin
      num[a] = 35'({vox_q[a], 1'b1}) * 35'(scale_q);
      rem_v  = r_q[a];
      qb[a]  = '0;
      for (int j = 0; j < 8; j++) begin
        rr = {rem_v, sh_q[a][39-j]};
        if (rr >= 4'(ponv_pkg::COORD_DIVISOR)) begin
          rem_v       = 3'(rr - 4'(ponv_pkg::COORD_DIVISOR));
          qb[a][7-j]  = 1'b1;
        end else begin
          rem_v = rr[2:0];
        end
      end
      r_nx[a] = rem_v;
    end
  end

  assign zwh_full = 32'(zw_q) * 32'(vh_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_start) begin
      vox_q[0] <= item_i.voxel_x;
      vox_q[1] <= item_i.voxel_y;
      vox_q[2] <= item_i.voxel_z;
    end
    for (int a = 0; a < 3; a++) begin
      if (cmd_i.mul_en) begin
        sh_q[a] <= {7'd0, num[a][34:2]};
        r_q[a]  <= '0;
      end else if (cmd_i.cdiv_en) begin
        sh_q[a]    <= {sh_q[a][31:0], 8'd0};
        r_q[a]     <= r_nx[a];
        coord_q[a] <= {coord_q[a][15:0], qb[a]};
      end else if (cmd_i.acc_en) begin
        coord_q[a] <= {coord_q[a][22:0], 1'b0};
      end
    end
    if (cmd_i.mul_en) begin
      yw_q <= 21'(vox_q[1]) * 21'(vw_q);
      zw_q <= 21'(vox_q[2]) * 21'(vw_q);
    end
    zwh_q <= zwh_full[29:0];
    idx_q <= 30'(vox_q[0]) + 30'(yw_q) + zwh_q;
  end

  // Fade lanes, one multiplier per axis over three steps.
  logic [31:0] fm_q   [3];
  logic [19:0] qp_q   [3];
  logic [16:0] fade_q [3];
  logic [19:0] qn     [3];
  logic [35:0] fprod  [3];

  always_comb begin
    logic [15:0] t, opa;
    logic [19:0] opb;
    logic [34:0] six;
    logic [21:0] qsum;
    for (int a = 0; a < 3; a++) begin
      t     = coord_q[a][15:0];
      six   = {fm_q[a], 2'b0} + {1'b0, fm_q[a], 1'b0};
      qsum  = 22'd655360 + 22'(six[34:16]) - 22'({t, 4'd0} - {4'd0, t});
      qn[a] = qsum[19:0];
      opa   = (cmd_i.fade_step == ponv_pkg::FS_SQUARE) ? t : fm_q[a][31:16];
      opb   = (cmd_i.fade_step == ponv_pkg::FS_POLY) ? qp_q[a] : {4'd0, t};
      fprod[a] = 36'(opa) * 36'(opb);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fade_en) begin
      for (int a = 0; a < 3; a++) begin
        case (cmd_i.fade_step)
          ponv_pkg::FS_SQUARE: fm_q[a] <= fprod[a][31:0];
          ponv_pkg::FS_CUBE: begin
            fm_q[a] <= fprod[a][31:0];
            qp_q[a] <= qn[a];
          end
          ponv_pkg::FS_POLY: fade_q[a] <= fprod[a][32:16];
          default: ;
        endcase
      end
    end
  end

  // Permutation memory and the hash read sequence.
  logic [7:0] perm_mem [ponv_pkg::TABLE_SIZE];
  logic [7:0] rd_q, rd_addr;
  logic [3:0] tag_q;
  logic       tag_vld_q;
  logic [7:0] a_q, b_q, aa_q, ab_q, ba_q, bb_q;
  logic [3:0] hash_q [8];
  logic [2:0] rd_k, tag_k;
  logic [7:0] base;

  assign rd_k  = 3'(cmd_i.rd_sel - ponv_pkg::RD_CORNER);
  assign tag_k = 3'(tag_q - ponv_pkg::RD_CORNER);

  always_comb begin
    case (rd_k[1:0])
      2'd0:    base = aa_q;
      2'd1:    base = ba_q;
      2'd2:    base = ab_q;
      default: base = bb_q;
    endcase
    case (cmd_i.rd_sel)
      ponv_pkg::RD_PX:  rd_addr = coord_q[0][23:16];
      ponv_pkg::RD_PX1: rd_addr = coord_q[0][23:16] + 8'd1;
      ponv_pkg::RD_PA:  rd_addr = a_q;
      ponv_pkg::RD_PA1: rd_addr = a_q + 8'd1;
      ponv_pkg::RD_PB:  rd_addr = b_q;
      ponv_pkg::RD_PB1: rd_addr = b_q + 8'd1;
      default:          rd_addr = base + {7'd0, rd_k[2]};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.perm_we) begin
      perm_mem[item_i.perm_index] <= item_i.perm_value;
    end
    if (cmd_i.rd_en) begin
      rd_q <= perm_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_vld_q <= 1'b0;
      tag_q     <= '0;
    end else begin
      tag_vld_q <= cmd_i.rd_en;
      tag_q     <= cmd_i.rd_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_vld_q) begin
      case (tag_q)
        ponv_pkg::RD_PX:  a_q  <= rd_q + coord_q[1][23:16];
        ponv_pkg::RD_PX1: b_q  <= rd_q + coord_q[1][23:16];
        ponv_pkg::RD_PA:  aa_q <= rd_q + coord_q[2][23:16];
        ponv_pkg::RD_PA1: ab_q <= rd_q + coord_q[2][23:16];
        ponv_pkg::RD_PB:  ba_q <= rd_q + coord_q[2][23:16];
        ponv_pkg::RD_PB1: bb_q <= rd_q + coord_q[2][23:16];
        default:          hash_q[tag_k] <= rd_q[3:0];
      endcase
    end
  end

  // Corner gradients; the far corner's offset is the fraction minus one.
  logic signed [NW-1:0] grad_w [8];

  for (genvar k = 0; k < 8; k++) begin : g_corner
    logic signed [16:0] gx, gy, gz;
    assign gx = {((k % 2) != 0), coord_q[0][15:0]};
    assign gy = {(((k / 2) % 2) != 0), coord_q[1][15:0]};
    assign gz = {((k / 4) != 0), coord_q[2][15:0]};
    assign grad_w[k] = grad_f(hash_q[k], gx, gy, gz);
  end

  // Shared lerp unit.
  logic signed [NW-1:0] l00_q, l10_q, l01_q, l11_q, m0_q, m1_q, nz_q;
  logic signed [NW-1:0] la, lb, lres;
  logic [16:0]          lt;
  logic signed [NW:0]   ldiff;
  logic signed [37:0]   lprod;

  always_comb begin
    case (cmd_i.lerp_step)
      LS_Y0Z0: begin la = grad_w[0]; lb = grad_w[1]; lt = fade_q[0]; end
      LS_Y1Z0: begin la = grad_w[2]; lb = grad_w[3]; lt = fade_q[0]; end
      LS_Y0Z1: begin la = grad_w[4]; lb = grad_w[5]; lt = fade_q[0]; end
      LS_Y1Z1: begin la = grad_w[6]; lb = grad_w[7]; lt = fade_q[0]; end
      LS_Z0:   begin la = l00_q;     lb = l10_q;     lt = fade_q[1]; end
      LS_Z1:   begin la = l01_q;     lb = l11_q;     lt = fade_q[1]; end
      default: begin la = m0_q;      lb = m1_q;      lt = fade_q[2]; end
    endcase
    ldiff = (NW+1)'(lb) - (NW+1)'(la);
    lprod = 38'(ldiff) * 38'($signed({1'b0, lt}));
    lres  = la + NW'(lprod >>> ponv_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lerp_en) begin
      case (cmd_i.lerp_step)
        LS_Y0Z0: l00_q <= lres;
        LS_Y1Z0: l10_q <= lres;
        LS_Y0Z1: l01_q <= lres;
        LS_Y1Z1: l11_q <= lres;
        LS_Z0:   m0_q  <= lres;
        LS_Z1:   m1_q  <= lres;
        LS_OUT:  nz_q  <= lres;
        default: ;
      endcase
    end
  end

  // Octave accumulation.
  logic signed [ponv_pkg::TOTAL_W-1:0] total_q;
  logic [ponv_pkg::AMP_SUM_W-1:0]      amp_sum_q;
  logic [16:0]                         amp_q;
  logic signed [36:0]                  accp;
  logic [32:0]                         ampn;

  assign accp = 37'(nz_q) * 37'($signed({1'b0, amp_q}));
  assign ampn = 33'(amp_q) * 33'(pers_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_start) begin
      total_q   <= '0;
      amp_sum_q <= '0;
      amp_q     <= 17'd65536;
    end else if (cmd_i.acc_en) begin
      total_q   <= total_q + ponv_pkg::TOTAL_W'(accp);
      amp_sum_q <= amp_sum_q + ponv_pkg::AMP_SUM_W'(amp_q);
      amp_q     <= ampn[32:16];
    end
  end

  // Normalisation through the divider, on magnitudes.
  logic [ponv_pkg::TOTAL_W-1:0] mag, quo;
  logic                         neg_q;

  assign mag = total_q[ponv_pkg::TOTAL_W-1] ? (~total_q + 1'b1) : total_q;

  ponv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mag),
    .divisor_i  (amp_sum_q),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= total_q[ponv_pkg::TOTAL_W-1];
    end
  end

  // Map [-1,1] to [0,1] and saturate.
  logic signed [25:0] nval, val;
  logic [15:0]        dens;

  always_comb begin
    nval = $signed({2'b00, quo[23:0]});
    if (neg_q) begin
      nval = -nval;
    end
    val = nval + 26'sd65536;
    if (val < 0) begin
      dens = '0;
    end else if (val[25:1] > 25'd65535) begin
      dens = 16'hFFFF;
    end else begin
      dens = val[16:1];
    end
  end

  ponv_pkg::result_t res_q;
  logic              done_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q.density     <= dens;
      res_q.voxel_index <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.out_load;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

@@ sv/ponv_ctrl.sv @@
// Controller: sequences scaling, per-octave reads, lerps, accumulation and
// the final division. Depends on ponv_pkg for the command and status types.
`default_nettype none

module ponv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              func_i,
  output logic              busy,
  output ponv_pkg::cmd_t    cmd_o,
  input  ponv_pkg::status_t status_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_CDIV,
    S_RD,
    S_LERP,
    S_ACC,
    S_DIVGO,
    S_DIVW,
    S_FIN
  } state_e;

  state_e                      state_q, state_d;
  logic [3:0]                  cnt_q, cnt_d;
  logic [ponv_pkg::OCT_W-1:0]  oct_q, oct_d;
  logic                        busy_q;
  logic                        accept, last_oct;

  assign accept   = start && !busy_q;
  assign last_oct = ({1'b0, oct_q} == (status_i.n_oct - 4'd1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    oct_d   = oct_q;
    case (state_q)
      S_IDLE: begin
        if (accept && func_i) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_CDIV;
        cnt_d   = '0;
      end
      S_CDIV: begin
        if (cnt_q == 4'(ponv_pkg::CDIV_STEPS - 1)) begin
          state_d = S_RD;
          cnt_d   = '0;
          oct_d   = '0;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_RD: begin
        // The last count step issues no read, so the last table read can land.
        if (cnt_q == 4'(ponv_pkg::RD_STEPS)) begin
          state_d = S_LERP;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_LERP: begin
        if (cnt_q == 4'(ponv_pkg::LERP_STEPS - 1)) begin
          state_d = S_ACC;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_ACC: begin
        cnt_d = '0;
        if (last_oct) begin
          state_d = S_DIVGO;
        end else begin
          state_d = S_RD;
          oct_d   = oct_q + 1'b1;
        end
      end
      S_DIVGO: state_d = S_DIVW;
      S_DIVW: begin
        if (status_i.div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      oct_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      oct_q   <= oct_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.perm_we    = accept && !func_i;
    cmd_o.eval_start = accept && func_i;
    cmd_o.mul_en     = (state_q == S_MUL);
    cmd_o.cdiv_en    = (state_q == S_CDIV);
    cmd_o.fade_en    = (state_q == S_RD) && (cnt_q < 4'(ponv_pkg::FADE_STEPS));
    cmd_o.fade_step  = cnt_q[1:0];
    cmd_o.rd_en      = (state_q == S_RD) && (cnt_q < 4'(ponv_pkg::RD_STEPS));
    cmd_o.rd_sel     = cnt_q;
    cmd_o.lerp_en    = (state_q == S_LERP);
    cmd_o.lerp_step  = cnt_q[2:0];
    cmd_o.acc_en     = (state_q == S_ACC);
    cmd_o.div_start  = (state_q == S_DIVGO);
    cmd_o.out_load   = (state_q == S_FIN);
  end

  assign busy = busy_q;

  a_eval_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy_q && func_i) |=> busy_q)
    else $error("evaluation item accepted without going busy");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy_q && !func_i) |=> !busy_q)
    else $error("table load item made the block busy");

  a_div_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == S_DIVW))
    else $error("divider finished outside its wait state");

  a_fin_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> !busy_q)
    else $error("block still busy after delivering a result");

endmodule

`default_nettype wire

@@ sv/perlin_octave_noise_volume_top.sv @@
// Top level of the fractal Perlin noise volume block: controller and datapath.
// Depends on ponv_pkg, ponv_ctrl and ponv_dp.
//
//   Channel   Handshake                    Payload
//   input     start / busy                 item_i   (ponv_pkg::item_t)
//   result    done_o, one-cycle strobe     result_o (ponv_pkg::result_t)
//   config    cfg_we_i, cfg_idx_i          cfg_data_i
//
// A table load item is written to the permutation table; busy does not rise.
// An evaluation runs coordinate scaling, then for each of N octaves (four at
// reset) the 14 reads of the permutation memory's single read port and the
// 7 blends of the shared lerp unit, then the bit-serial normalising divider.
// After reset the block is idle; the permutation table holds nothing
// until loaded. The receiver cannot stall; the result strobe lasts one cycle.
`default_nettype none

module perlin_octave_noise_volume_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  ponv_pkg::item_t                item_i,
  output logic                           done_o,
  output ponv_pkg::result_t              result_o,
  input  logic                           cfg_we_i,
  input  logic [ponv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ponv_pkg::CFG_W-1:0]     cfg_data_i
);

  ponv_pkg::cmd_t    cmd;
  ponv_pkg::status_t status;

  ponv_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .func_i   (item_i.func),
    .busy     (busy),
    .cmd_o    (cmd),
    .status_i (status)
  );

  ponv_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule

`default_nettype wire
